// ===== rtl/lsrg_pkg.sv =====
// ----------------------------------------------------------------------------
// lsrg_pkg
// Shared types and constants of the shuffled Lehmer random generator.
// ----------------------------------------------------------------------------
package lsrg_pkg;

   localparam int VALUE_W = 31;
   localparam int MUL_W   = 15;
   localparam int LPROD_W = VALUE_W + MUL_W;

   localparam logic [MUL_W-1:0]   LCG_MUL = 15'd16807;
   localparam logic [VALUE_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] OUT_MAX = 31'd2147483389;

   // Warm-up steps run beyond the table depth at initialization.
   localparam int WARMUP_EXTRA = 8;
   // Fraction bits of the reciprocal used to find the table slot.
   localparam int RECIP_SHIFT  = 37;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT_MUL,
      ST_INIT_RED,
      ST_DRAW_MUL,
      ST_DRAW_SLOT,
      ST_DRAW_READ,
      ST_DRAW_DONE
   } lsrg_state_type;

   typedef struct packed {
      logic load_seed;
      logic lcg_mul;
      logic lcg_reduce;
      logic warm_step;
      logic slot_mul;
      logic slot_calc;
      logic table_read;
      logic finish;
   } lsrg_cmd_type;

   typedef struct packed {
      logic need_init;
      logic warm_last;
      logic out_free;
   } lsrg_status_type;

endpackage

// ===== rtl/lsrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// lsrg_ctrl
// Sequencer for warm-up and draws; drives the datapath by command word.
// ----------------------------------------------------------------------------
module lsrg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_reseed,
   output logic                      req_ready,
   input  lsrg_pkg::lsrg_status_type status,
   output lsrg_pkg::lsrg_cmd_type    cmd
);
   import lsrg_pkg::*;

   lsrg_state_type state_ff;
   lsrg_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_reseed || status.need_init) begin
                  cmd.load_seed = 1'b1;
                  state_in      = ST_INIT_MUL;
               end else begin
                  // The first multiplies of the draw overlap the accept cycle.
                  cmd.lcg_mul  = 1'b1;
                  cmd.slot_mul = 1'b1;
                  state_in     = ST_DRAW_SLOT;
               end
            end
         end
         ST_INIT_MUL: begin
            cmd.lcg_mul = 1'b1;
            state_in    = ST_INIT_RED;
         end
         ST_INIT_RED: begin
            cmd.lcg_reduce = 1'b1;
            cmd.warm_step  = 1'b1;
            state_in       = status.warm_last ? ST_DRAW_MUL : ST_INIT_MUL;
         end
         ST_DRAW_MUL: begin
            cmd.lcg_mul  = 1'b1;
            cmd.slot_mul = 1'b1;
            state_in     = ST_DRAW_SLOT;
         end
         ST_DRAW_SLOT: begin
            cmd.lcg_reduce = 1'b1;
            cmd.slot_calc  = 1'b1;
            state_in       = ST_DRAW_READ;
         end
         ST_DRAW_READ: begin
            cmd.table_read = 1'b1;
            state_in       = ST_DRAW_DONE;
         end
         ST_DRAW_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/lsrg_datapath.sv =====
// ----------------------------------------------------------------------------
// lsrg_datapath
// Lehmer step, slot selection, shuffle table and output word register.
// ----------------------------------------------------------------------------
module lsrg_datapath #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lsrg_pkg::lsrg_cmd_type       cmd,
   output lsrg_pkg::lsrg_status_type    status,
   input  logic                         csr_valid,
   input  logic [lsrg_pkg::VALUE_W-1:0] csr_seed_magnitude,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lsrg_pkg::VALUE_W-1:0] rsp_uniform_value
);
   import lsrg_pkg::*;

   localparam int SLOT_W     = $clog2(TABLE_DEPTH);
   localparam int WARM_COUNT = TABLE_DEPTH + WARMUP_EXTRA;
   localparam int WARM_W     = $clog2(WARM_COUNT);
   localparam longint unsigned SLOT_DIV = 64'd1 + 64'd2147483646 / 64'(TABLE_DEPTH);
   localparam longint unsigned RECIP    = (64'd1 << RECIP_SHIFT) / SLOT_DIV;
   localparam int RPROD_W    = RECIP_SHIFT + SLOT_W + 1;

   logic [VALUE_W-1:0] seed_ff, seed_in;
   logic [VALUE_W-1:0] lehmer_ff, lehmer_in;
   logic [LPROD_W-1:0] lprod_ff, lprod_in;
   logic [RPROD_W-1:0] rprod_ff, rprod_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [WARM_W-1:0]  warm_ff, warm_in;
   logic [VALUE_W-1:0] last_ff, last_in;
   logic [VALUE_W-1:0] rdata_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic [VALUE_W-1:0] table_mem [TABLE_DEPTH];

   logic [VALUE_W:0]   lsum;
   logic [VALUE_W-1:0] lcg_red;
   logic [VALUE_W-1:0] seed_fix;
   logic [SLOT_W-1:0]  q_est;
   logic [VALUE_W-1:0] qk;
   logic [VALUE_W-1:0] rem;
   logic [SLOT_W:0]    slot_sum;
   logic               warm_in_table;
   logic               tbl_we;
   logic [SLOT_W-1:0]  tbl_waddr;
   logic [VALUE_W-1:0] tbl_wdata;

   // 2^31 = 1 mod (2^31 - 1), so the high part folds onto the low part.
   assign lsum    = {1'b0, lprod_ff[VALUE_W-1:0]} + (VALUE_W+1)'(lprod_ff[LPROD_W-1:VALUE_W]);
   assign lcg_red = (lsum >= {1'b0, LCG_MOD}) ? VALUE_W'(lsum - {1'b0, LCG_MOD})
                                              : lsum[VALUE_W-1:0];

   // Both zero and the modulus itself would leave the generator stuck at zero.
   assign seed_fix = (seed_ff == '0 || seed_ff == LCG_MOD) ? VALUE_W'(1) : seed_ff;

   // The reciprocal estimate is low by at most one; one compare corrects it.
   assign q_est    = rprod_ff[RECIP_SHIFT +: SLOT_W];
   assign qk       = VALUE_W'(q_est) * VALUE_W'(SLOT_DIV);
   assign rem      = last_ff - qk;
   assign slot_sum = {1'b0, q_est} + (SLOT_W+1)'(rem >= VALUE_W'(SLOT_DIV));

   assign warm_in_table = (warm_ff < WARM_W'(TABLE_DEPTH));

   assign tbl_we    = (cmd.warm_step && warm_in_table) || cmd.finish;
   assign tbl_waddr = cmd.finish ? slot_ff : warm_ff[SLOT_W-1:0];
   assign tbl_wdata = cmd.finish ? lehmer_ff : lcg_red;

   always_comb begin
      seed_in      = csr_valid ? csr_seed_magnitude : seed_ff;
      lehmer_in    = lehmer_ff;
      lprod_in     = lprod_ff;
      rprod_in     = rprod_ff;
      slot_in      = slot_ff;
      warm_in      = warm_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;

      if (cmd.load_seed) begin
         lehmer_in = seed_fix;
         warm_in   = WARM_W'(WARM_COUNT - 1);
      end
      if (cmd.lcg_mul) begin
         lprod_in = LPROD_W'(lehmer_ff) * LPROD_W'(LCG_MUL);
      end
      if (cmd.lcg_reduce) begin
         lehmer_in = lcg_red;
      end
      if (cmd.warm_step) begin
         if (warm_ff == '0) begin
            last_in = lcg_red;
         end else begin
            warm_in = warm_ff - WARM_W'(1);
         end
      end
      if (cmd.slot_mul) begin
         rprod_in = RPROD_W'(last_ff) * RPROD_W'(RECIP);
      end
      if (cmd.slot_calc) begin
         slot_in = (slot_sum >= (SLOT_W+1)'(TABLE_DEPTH)) ? '0 : slot_sum[SLOT_W-1:0];
      end
      if (cmd.finish) begin
         last_in      = rdata_ff;
         rsp_valid_in = 1'b1;
         rsp_value_in = (rdata_ff > OUT_MAX) ? OUT_MAX : rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= VALUE_W'(1);
         lehmer_ff    <= VALUE_W'(1);
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         lehmer_ff    <= lehmer_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lprod_ff     <= lprod_in;
      rprod_ff     <= rprod_in;
      slot_ff      <= slot_in;
      warm_ff      <= warm_in;
      rsp_value_ff <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         table_mem[tbl_waddr] <= tbl_wdata;
      end
      if (cmd.table_read) begin
         rdata_ff <= table_mem[slot_ff];
      end
   end

   assign status.need_init = (last_ff == '0);
   assign status.warm_last = (warm_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_uniform_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_lehmer_in_range: assert property (@(posedge clock) disable iff (reset)
      lehmer_ff != '0 && lehmer_ff != LCG_MOD)
      else $error("Lehmer state left the range 1 to modulus minus one");

   a_init_sets_last: assert property (@(posedge clock) disable iff (reset)
      cmd.warm_step && warm_ff == '0 |=> last_ff != '0)
      else $error("Initialization ended with a zero output latch");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff || rsp_ready)
      else $error("Output word overwritten before it was taken");

   a_value_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_value_ff <= OUT_MAX)
      else $error("Output word above the saturation limit");

   a_slot_estimate: assert property (@(posedge clock) disable iff (reset)
      cmd.slot_calc |-> {1'b0, rem} < (VALUE_W+1)'(2 * SLOT_DIV))
      else $error("Slot reciprocal estimate is off by more than one");
`endif

endmodule

// ===== rtl/lehmer_shuffle_random_generator.sv =====
// ----------------------------------------------------------------------------
// lehmer_shuffle_random_generator
// Minimal-standard Lehmer generator (16807 mod 2^31-1) behind a shuffle table.
//
// Each word accepted on the req_ channel yields one word on the rsp_ channel:
// a 31-bit fraction of 2^31-1, saturated at 2147483389. req_reseed set forces
// a fresh start from the seed register before the draw. csr_ writes the seed
// register; the port is always ready, and the user must write it only while idle,
// as the block itself has no guard for it. A plain draw runs the Lehmer
// multiply, the slot reduction, the registered table read and the output
// handover in that order, and the block takes no new request until the
// handover of the last one. The first request after reset, or a reseed,
// first runs the warm-up Lehmer steps, each a multiply then a reduce through
// the Lehmer multiplier, and its draw then starts with its own multiply, since
// that multiply no longer overlaps the accept.
// Reset clears the output latch, so the next request initializes; the table
// needs no clearing pass. When the receiver stalls, the finished word waits
// in the output register; one more request is accepted and drawn, then waits
// in its last step, and further requests are held off until the waiting word
// is taken.
// ----------------------------------------------------------------------------
module lehmer_shuffle_random_generator #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_reseed,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lsrg_pkg::VALUE_W-1:0] rsp_uniform_value,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lsrg_pkg::VALUE_W-1:0] csr_seed_magnitude
);
   import lsrg_pkg::*;

   lsrg_cmd_type    cmd;
   lsrg_status_type status;

   assign csr_ready = 1'b1;

   lsrg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_reseed (req_reseed),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   lsrg_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_seed_magnitude (csr_seed_magnitude),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_uniform_value  (rsp_uniform_value)
   );

endmodule

// ===== sim/lehmer_shuffle_random_generator_tb.sv =====
// ----------------------------------------------------------------------------
// lehmer_shuffle_random_generator_tb
// Self-checking bench for the shuffled Lehmer random generator.
//
// Draw requests go in on req_ and every returned word is compared with a
// predictor that is kept in step with the generator: the same Lehmer core,
// the same shuffle table and the same seed register. A few directed draws
// cover the reset seed, the corner seeds and output saturation. Random
// streams with occasional reseeds follow, under three different patterns
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module lehmer_shuffle_random_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 32;
   localparam int WARMUP = DEPTH + 8;
   localparam int ITEMS_PER_PHASE = 345;
   localparam int RESEED_PCT = 3;
   localparam longint unsigned MULT = 64'd16807;
   localparam longint unsigned MODULUS = 64'd2147483647;
   localparam longint unsigned SLOT_SPAN = 1 + (MODULUS - 1) / DEPTH;
   localparam logic [30:0] SAT_LIMIT = 31'd2147483389;

   typedef logic [lsrg_pkg::VALUE_W-1:0] value_type;

   logic      clock;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_reseed = 1'b0;
   logic      rsp_ready = 1'b0;
   logic      csr_valid = 1'b0;
   value_type csr_seed_magnitude = '0;
   logic      req_ready;
   logic      rsp_valid;
   logic      csr_ready;
   value_type rsp_uniform_value;

   // Predictor state.
   value_type seed_reg = 31'd1;
   value_type lehmer_q = 31'd1;
   value_type last_q = '0;
   value_type shuffle_q [DEPTH];
   value_type expected_values [$];

   int errors = 0;
   int draws = 0;
   int reseeds = 0;
   int seed_writes = 0;
   int matched = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   lehmer_shuffle_random_generator #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_reseed        (req_reseed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_uniform_value (rsp_uniform_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_seed_magnitude(csr_seed_magnitude)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic value_type lehmer_advance(value_type s);
      return value_type'((64'(s) * MULT) % MODULUS);
   endfunction

   function automatic void predict_draw(logic reseed);
      value_type s;
      int slot;
      int j;
      if (reseed || last_q == '0) begin
         s = value_type'(64'(seed_reg) % MODULUS);
         if (s == '0) s = 31'd1;
         for (j = WARMUP - 1; j >= 0; j--) begin
            s = lehmer_advance(s);
            if (j < DEPTH) shuffle_q[j] = s;
         end
         lehmer_q = s;
         last_q = shuffle_q[0];
      end
      lehmer_q = lehmer_advance(lehmer_q);
      slot = int'(64'(last_q) / SLOT_SPAN);
      if (slot >= DEPTH) slot = 0;
      last_q = shuffle_q[slot];
      shuffle_q[slot] = lehmer_q;
      expected_values.push_back((last_q > SAT_LIMIT) ? SAT_LIMIT : last_q);
   endfunction

   // Table entry 31 holds the ninth warm-up value. Choosing that value above
   // the saturation point and walking back nine steps gives a candidate seed;
   // it is kept when entry 0 also selects slot 31, so the first draw saturates.
   function automatic value_type saturating_seed();
      longint unsigned inv9;
      longint unsigned base;
      longint unsigned e;
      longint unsigned x;
      longint unsigned seed;
      value_type s;
      inv9 = 1;
      base = MULT;
      e = MODULUS - 10;
      while (e != 0) begin
         if (e[0]) inv9 = (inv9 * base) % MODULUS;
         base = (base * base) % MODULUS;
         e = e >> 1;
      end
      for (x = MODULUS - 1; x > SAT_LIMIT; x--) begin
         seed = (x * inv9) % MODULUS;
         s = value_type'(seed);
         repeat (WARMUP) s = lehmer_advance(s);
         if (64'(s) / SLOT_SPAN == DEPTH - 1) return value_type'(seed);
      end
      return 31'd1;
   endfunction

   // Called right after the clock rises; returns as soon as the generator has taken the word.
   task automatic send_draw(input logic reseed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_reseed <= reseed;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_draw(reseed);
      draws++;
      if (reseed) reseeds++;
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (expected_values.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (expected_values.size() != 0) begin
         $error("rsp_uniform_value: %0d words never arrived", expected_values.size());
         errors++;
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_seed(input value_type seed);
      csr_valid <= 1'b1;
      csr_seed_magnitude <= seed;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      seed_reg = seed;
      seed_writes++;
      @(posedge clock);
   endtask

   // The first draw after reset must initialize on its own from the reset seed.
   task automatic test_reset_seed();
      send_draw(1'b0);
      send_draw(1'b0);
      send_draw(1'b0);
      send_draw(1'b1);
      send_draw(1'b0);
      wait_drained();
   endtask

   // Five corner seeds each start a reseeding draw; zero and the modulus itself both fall back to a seed of one.
   task automatic test_seed_corners();
      value_type corners [5];
      int k;
      corners = '{31'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFE, 31'h2AAA_AAAA,
                  31'h5555_5555};
      for (k = 0; k < 5; k++) begin
         write_seed(corners[k]);
         send_draw(1'b1);
         send_draw(1'b0);
         wait_drained();
      end
   endtask

   task automatic test_saturation();
      write_seed(saturating_seed());
      send_draw(1'b1);
      send_draw(1'b0);
      send_draw(1'b1);
      wait_drained();
   endtask

   task automatic test_random_stream(input int send_pct, input int recv_pct);
      value_type seed;
      int pick;
      int i;
      seed = value_type'($urandom);
      pick = $urandom_range(9);
      if (pick == 0) seed = '0;
      else if (pick == 1) seed = '1;
      write_seed(seed);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      send_draw(1'b1);
      for (i = 1; i < ITEMS_PER_PHASE; i++) begin
         // Halfway through, hold the sender until every word has come back.
         if (i == ITEMS_PER_PHASE / 2) wait_drained();
         send_draw($urandom_range(99) < RESEED_PCT);
      end
      wait_drained();
   endtask

   always @(posedge clock) begin
      value_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_values.size() == 0) begin
            $error("rsp_uniform_value: unexpected word %0d with no draw outstanding",
                   rsp_uniform_value);
            errors++;
         end else begin
            want = expected_values.pop_front();
            if (rsp_uniform_value !== want) begin
               $error("rsp_uniform_value: expected %0d, actual %0d", want,
                      rsp_uniform_value);
               errors++;
            end else begin
               matched++;
            end
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_seed();
      test_seed_corners();
      test_saturation();
      test_random_stream(30, 83);
      test_random_stream(83, 30);
      test_random_stream(0, 0);
      repeat (100) @(posedge clock);
      $display("Ran %0d draws, %0d of them reseeding, across %0d seed writes; %0d words matched.",
               draws, reseeds, seed_writes, matched);
      $display("Included zero, modulus and saturating seeds and three stall patterns.");
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $error("timeout: the run did not finish in time");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
